@@ sv/csma_pkg.sv @@
// Shared types, constants and arithmetic helpers of the cross-spectral matrix accumulator.
`timescale 1ns / 1ps
`default_nettype none
package csma_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned SUBL     = 4;
  localparam int unsigned PAIRS    = SUBL * SUBL;
  localparam int unsigned PAIR_W   = $clog2(PAIRS);
  localparam int unsigned SUBL_W   = $clog2(SUBL);
  localparam int unsigned OBS      = 8;
  localparam int unsigned OBS_W    = 3;
  localparam int unsigned Q_POINTS = 512;
  localparam int unsigned Q_W      = 9;
  localparam int unsigned ADDR_W   = OBS_W + Q_W;
  localparam int unsigned DEPTH    = OBS * Q_POINTS;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned PSUM_W   = PROD_W + 1;
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 120;

  typedef enum logic {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } act_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [SUBL-1:0] sample_vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef psum_t [PAIRS-1:0] psum_vec_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] im;
    logic signed [SUM_W-1:0] re;
  } csum_t;

  typedef csum_t [PAIRS-1:0] sum_vec_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic              vld;
    act_e              act;
    logic              flast;
    logic [ADDR_W-1:0] addr;
  } ctl_t;

  // Saturating add of a product term to a stored sum.
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input psum_t p);
    logic signed [SUM_W:0] wide;
    logic signed [SUM_W-1:0] res;
    wide = (SUM_W+1)'(s) + (SUM_W+1)'(p);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      res = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      res = wide[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ sv/csma_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module csma_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 96
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/csma_mult.sv @@
// Two-stage outer-product unit: registered partial products, then registered pair sums.
`timescale 1ns / 1ps
`default_nettype none
module csma_mult
  import csma_pkg::*;
(
  input  wire logic        clk_i,
  input  wire sample_vec_t re_i,
  input  wire sample_vec_t im_i,
  output psum_vec_t        pr_o,
  output psum_vec_t        pi_o
);

  prod_t [PAIRS-1:0] ac_q, bd_q, bc_q, ad_q;
  psum_vec_t pr_q, pi_q;

  // Re = a*c + b*d and Im = b*c - a*d for X_i = a+ib, X_j = c+id.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SUBL; i++) begin
      for (int j = 0; j < SUBL; j++) begin
        ac_q[i*SUBL+j] <= re_i[i] * re_i[j];
        bd_q[i*SUBL+j] <= im_i[i] * im_i[j];
        bc_q[i*SUBL+j] <= im_i[i] * re_i[j];
        ad_q[i*SUBL+j] <= re_i[i] * im_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PAIRS; k++) begin
      pr_q[k] <= PSUM_W'(ac_q[k]) + PSUM_W'(bd_q[k]);
      pi_q[k] <= PSUM_W'(bc_q[k]) - PSUM_W'(ad_q[k]);
    end
  end

  assign pr_o = pr_q;
  assign pi_o = pi_q;

endmodule
`default_nettype wire

@@ sv/csma_drain.sv @@
// Read-out buffer that sends the sixteen sums of one read as a stream of items.
`timescale 1ns / 1ps
`default_nettype none
module csma_drain
  import csma_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire sum_vec_t           sums_i,
  input  wire logic [COUNT_W-1:0] count_i,
  output logic                    busy_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [SUBL_W-1:0]       src_o,
  output logic [SUBL_W-1:0]       dst_o,
  output csum_t                   head_o,
  output logic [COUNT_W-1:0]      count_o,
  output logic                    last_o
);

  sum_vec_t buf_q, buf_d;
  logic [COUNT_W-1:0] count_q;
  logic [PAIR_W:0] left_q, left_d;
  logic [PAIR_W-1:0] pos;

  always_comb begin
    buf_d  = buf_q;
    left_d = left_q;
    if (load_i) begin
      buf_d  = sums_i;
      left_d = (PAIR_W+1)'(PAIRS);
    end else if (valid_o && ready_i) begin
      buf_d  = {csum_t'('0), buf_q[PAIRS-1:1]};
      left_d = left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (load_i) begin
      count_q <= count_i;
    end
  end

  assign pos     = PAIR_W'((PAIR_W+1)'(PAIRS) - left_q);
  assign busy_o  = (left_q != '0);
  assign valid_o = busy_o;
  assign src_o   = pos[PAIR_W-1:SUBL_W];
  assign dst_o   = pos[SUBL_W-1:0];
  assign head_o  = buf_q[0];
  assign count_o = count_q;
  assign last_o  = (left_q == (PAIR_W+1)'(1));

endmodule
`default_nettype wire

@@ sv/cross_spectral_matrix_accumulator.sv @@
// Top level of the cross-spectral matrix accumulator: pipeline, banked sum store and control.
// Pipeline: an accumulate item updates the store at the end of stage C; the first result of a
// read leaves the read-out buffer after stage C, then one per cycle while the output is ready.
// Throughput: one accumulate item per cycle while the input is ready, set by the three-stage
// read-modify-write pipeline over sixteen sum banks; a read holds the input until it drains.
// Reset: asynchronous, active low; afterwards a clearing pass over all 4096 addresses zeroes
// the store, with the input not ready, while configuration writes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module cross_spectral_matrix_accumulator
  import csma_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [OBS-1:0]        cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // Fields from bit 0 up: q_point, re_zero, im_zero, re_one, im_one, re_two, im_two,
  // re_three, im_three, zero padding.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: action, observable.
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input  wire logic                  s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // Fields from bit 0 up: source_sublattice, dest_sublattice, sum_real, sum_imag,
  // frame_count, zero padding.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  // Configuration register: one enable bit per observable.
  logic [OBS-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // Clearing pass over the store after reset.
  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Input handshake. Only one read may be in flight, so the input waits while a read
  // travels down the pipeline or its sums are still being sent.
  ctl_t ctl_a_q, ctl_a_d, ctl_b_q, ctl_c_q;
  logic drain_busy;
  logic read_busy;
  logic in_acc;
  logic [OBS_W-1:0] in_obs;

  assign read_busy = (ctl_a_q.vld && ctl_a_q.act == ACT_READ)
                  || (ctl_b_q.vld && ctl_b_q.act == ACT_READ)
                  || (ctl_c_q.vld && ctl_c_q.act == ACT_READ)
                  || drain_busy;
  assign s_axis_tready_o = !clr_busy_q && !read_busy;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_obs = s_axis_tuser_i[OBS_W:1];

  // Stage A: the accepted item. Items of a masked observable enter as bubbles.
  always_comb begin
    ctl_a_d.vld   = in_acc && mask_q[in_obs];
    ctl_a_d.act   = act_e'(s_axis_tuser_i[0]);
    ctl_a_d.flast = s_axis_tlast_i;
    ctl_a_d.addr  = {in_obs, s_axis_tdata_i[Q_W-1:0]};
  end

  sample_vec_t re_a_q, im_a_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SUBL; i++) begin
      re_a_q[i] <= s_axis_tdata_i[Q_W + 2*i*SAMPLE_W +: SAMPLE_W];
      im_a_q[i] <= s_axis_tdata_i[Q_W + (2*i+1)*SAMPLE_W +: SAMPLE_W];
    end
  end

  // The control stages never stall: accumulates give no result, and a read is only let in
  // when the read-out buffer is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
    end
  end

  // Outer products: stage A to B partial products, B to C pair sums.
  psum_vec_t pr_c, pi_c;

  csma_mult u_mult (
    .clk_i (clk_i),
    .re_i  (re_a_q),
    .im_i  (im_a_q),
    .pr_o  (pr_c),
    .pi_o  (pi_c)
  );

  // Sixteen banks, one per matrix entry, addressed by observable and point. Read in stage A,
  // data in stage B, registered into stage C, written back at the end of stage C.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  sum_vec_t          mem_wdata, rdata_b, rdata_c_q;

  for (genvar k = 0; k < PAIRS; k++) begin : g_bank
    csma_ram #(
      .DEPTH (DEPTH),
      .WIDTH (2 * SUM_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (mem_waddr),
      .wdata_i (mem_wdata[k]),
      .raddr_i (ctl_a_q.addr),
      .rdata_o (rdata_b[k])
    );
  end

  always_ff @(posedge clk_i) begin
    rdata_c_q <= rdata_b;
  end

  // The data read for the item in stage C misses the writes of the two items just ahead of
  // it, so the last two write-backs are kept and forwarded, the newer one winning.
  logic              w1_vld_q, w2_vld_q;
  logic [ADDR_W-1:0] w1_addr_q, w2_addr_q;
  sum_vec_t          w1_data_q, w2_data_q;
  sum_vec_t          old_c, new_c;
  logic              acc_c, rd_c;

  assign acc_c = ctl_c_q.vld && ctl_c_q.act == ACT_ACCUM;
  assign rd_c  = ctl_c_q.vld && ctl_c_q.act == ACT_READ;

  always_comb begin
    old_c = rdata_c_q;
    if (w2_vld_q && w2_addr_q == ctl_c_q.addr) begin
      old_c = w2_data_q;
    end
    if (w1_vld_q && w1_addr_q == ctl_c_q.addr) begin
      old_c = w1_data_q;
    end
    for (int k = 0; k < PAIRS; k++) begin
      new_c[k].re = sat_add(old_c[k].re, pr_c[k]);
      new_c[k].im = sat_add(old_c[k].im, pi_c[k]);
    end
  end

  assign mem_we    = clr_busy_q || acc_c;
  assign mem_waddr = clr_busy_q ? clr_addr_q : ctl_c_q.addr;
  assign mem_wdata = clr_busy_q ? sum_vec_t'('0) : new_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_vld_q <= 1'b0;
      w2_vld_q <= 1'b0;
    end else begin
      w1_vld_q <= acc_c;
      w2_vld_q <= w1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_addr_q <= ctl_c_q.addr;
    w1_data_q <= new_c;
    w2_addr_q <= w1_addr_q;
    w2_data_q <= w1_data_q;
  end

  // Frame count, advanced in order in stage C; a read sees every earlier accumulate's mark.
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (acc_c && ctl_c_q.flast && count_q != '1) begin
      count_q <= count_q + 1'b1;
    end
  end

  // Read-out: the forwarded sums of a read are loaded whole and sent one entry per item.
  logic [SUBL_W-1:0]  src, dst;
  csum_t              head;
  logic [COUNT_W-1:0] out_count;

  csma_drain u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (rd_c),
    .sums_i  (old_c),
    .count_i (count_q),
    .busy_o  (drain_busy),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .src_o   (src),
    .dst_o   (dst),
    .head_o  (head),
    .count_o (out_count),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0, out_count, head.im, head.re, dst, src};

  // No item enters while the store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready_o)
    else $error("item accepted during clearing pass");

  // At most one read is in the pipeline or the read-out buffer at any time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_a_q.vld && ctl_a_q.act == ACT_READ, ctl_b_q.vld && ctl_b_q.act == ACT_READ,
              rd_c, drain_busy}))
    else $error("more than one read in flight");

  // A read reaches the buffer only when it is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_c |-> !drain_busy)
    else $error("read-out buffer overwritten");

  // Items only pass through stage C after the clearing pass is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_c_q.vld |-> !clr_busy_q)
    else $error("store written by item during clearing");

endmodule
`default_nettype wire
